// File: hdl/gbbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gbbs_pkg;

    // Fixed point default
    localparam int FRAC_BITS_DEF = 16;

    // Field widths
    localparam int POS_W  = 27;
    localparam int VEL_W  = 32;
    localparam int GRAV_W = 23;
    localparam int STEP_W = 17;
    localparam int REST_W = 17;
    localparam int MAP_W  = 11;

    // Stream words, zero padded to whole bytes
    localparam int IN_DATA_W  = 120;
    localparam int OUT_DATA_W = 120;
    localparam int IN_USER_W  = 1;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY     = 3'd0,
        CFG_TIME_STEP   = 3'd1,
        CFG_RESTITUTION = 3'd2,
        CFG_MAP_WIDTH   = 3'd3,
        CFG_MAP_HEIGHT  = 3'd4
    } t_cfg_idx;

    // Register reset values
    localparam logic [GRAV_W-1:0] GRAVITY_RST     = 23'd65536;
    localparam logic [STEP_W-1:0] TIME_STEP_RST   = 17'd65536;
    localparam logic [REST_W-1:0] RESTITUTION_RST = 17'd52429;
    localparam logic [MAP_W-1:0]  MAP_WIDTH_RST   = 11'd64;
    localparam logic [MAP_W-1:0]  MAP_HEIGHT_RST  = 11'd32;

    // Square root unit: 64-bit radicand, 32-bit root
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;

endpackage

`default_nettype wire

// File: hdl/gbbs_mul_serial.sv
`timescale 1ns / 1ps
`default_nettype none

// Shift-add multiplier: signed A times unsigned B, one bit of B per cycle,
// LSB first. Stops as soon as the remaining bits of B are all zero.
module gbbs_mul_serial
    import gbbs_pkg::*;
#(
    parameter int WA = VEL_W + 2,
    parameter int WB = VEL_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [WA-1:0]    i_a,
    input  logic        [WB-1:0]    i_b,
    output logic                    o_busy,
    output logic signed [WA+WB-1:0] o_prod
);

    localparam int WP = WA + WB;

    logic                 r_busy;
    logic signed [WP-1:0] r_a;
    logic        [WB-1:0] r_b;
    logic signed [WP-1:0] r_p;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_b == '0)) begin
            r_busy <= 1'b0;
        end
    end

    // Operand shift registers and accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= WP'(i_a);
            r_b <= i_b;
            r_p <= '0;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_p <= r_p + r_a;
            end
            r_a <= r_a <<< 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_p;

endmodule

`default_nettype wire

// File: hdl/gbbs_sqrt_serial.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring integer square root, one root bit per cycle.
// Two radicand bits shift in per step; ROOT_W steps give floor(sqrt(x)).
module gbbs_sqrt_serial
    import gbbs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_rad,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 2;
    localparam int TRY_W = REM_W + 2;

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [RAD_W-1:0]  r_x;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [TRY_W-1:0]  w_trial;
    logic [TRY_W-1:0]  w_sub;
    logic [TRY_W-1:0]  w_diff;
    logic              w_ge;

    // Trial subtract of (4*root + 1)
    always_comb begin
        w_trial = {r_rem, r_x[RAD_W-1 -: 2]};
        w_sub   = TRY_W'({r_root, 2'b01});
        w_ge    = (w_trial >= w_sub);
        w_diff  = w_trial - w_sub;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(ROOT_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x <= r_x << 2;
            if (w_ge) begin
                r_rem  <= w_diff[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_trial[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire

// File: hdl/gravity_bounce_body_step.sv
// A load word passes from the idle state through the output state into the output
// register. An advance word's time is set by the bit-serial multipliers and grows
// with the bit length of time_step; a floor or ceiling crossing adds the |vy|^2
// multiply and the square root, a bounce adds a multiply that grows with bits(restitution).
// Throughput: one word at a time; the output register lets the next word in early.
// Reset: synchronous, active low; body state cleared to zero, configuration registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module gravity_bounce_body_step
    import gbbs_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // load_pos_x, load_pos_y, load_vel_x, load_vel_y, zero pad
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    // pos_x, pos_y, vel_x, vel_y, on_ground, zero pad
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int F     = FRAC_BITS;
    // Stored position: loaded 27-bit value or clamped map limit
    localparam int WPS   = (POS_W > MAP_W + F) ? POS_W : MAP_W + F;
    // Position step magnitude stays below 2^(48-F)
    localparam int WDL   = 49 - F;
    localparam int WSUM  = ((WPS > WDL) ? WPS : WDL) + 1;
    localparam int WA    = (WSUM > VEL_W + 1) ? WSUM : VEL_W + 1;
    localparam int WB    = VEL_W;
    localparam int WP    = WA + WB;

    localparam logic signed [WP-1:0] SAT_HI = signed'(WP'({(VEL_W-1){1'b1}}));
    localparam logic signed [WP-1:0] SAT_LO = -SAT_HI - 1;

    typedef enum logic [13:0] {
        ST_IDLE = 14'h0001,
        ST_M1   = 14'h0002,
        ST_W1   = 14'h0004,
        ST_M2   = 14'h0008,
        ST_W2   = 14'h0010,
        ST_CHK  = 14'h0020,
        ST_M3   = 14'h0040,
        ST_W3   = 14'h0080,
        ST_SQS  = 14'h0100,
        ST_SQW  = 14'h0200,
        ST_BCHK = 14'h0400,
        ST_M4   = 14'h0800,
        ST_W4   = 14'h1000,
        ST_OUT  = 14'h2000
    } t_state;

    function automatic logic signed [VEL_W-1:0] f_sat(input logic signed [WP-1:0] v);
        if (v > SAT_HI) begin
            f_sat = SAT_HI[VEL_W-1:0];
        end else if (v < SAT_LO) begin
            f_sat = SAT_LO[VEL_W-1:0];
        end else begin
            f_sat = v[VEL_W-1:0];
        end
    endfunction

    // Registers
    t_state                   r_state, n_state;
    logic                     r_ovalid, n_ovalid;
    logic [OUT_DATA_W-1:0]    r_out, n_out;

    logic [GRAV_W-1:0]        r_g;
    logic [STEP_W-1:0]        r_dt;
    logic [REST_W-1:0]        r_rest;
    logic [MAP_W-1:0]         r_mw;
    logic [MAP_W-1:0]         r_mh;

    logic        [WPS-1:0]    r_px, n_px;
    logic        [WPS-1:0]    r_py, n_py;
    logic signed [VEL_W-1:0]  r_vx, n_vx;
    logic signed [VEL_W-1:0]  r_vy, n_vy;
    logic signed [VEL_W-1:0]  r_vn, n_vn;
    logic signed [WSUM-1:0]   r_sx, n_sx;
    logic signed [WSUM-1:0]   r_sy, n_sy;
    logic        [WSUM-1:0]   r_ov, n_ov;
    logic        [RAD_W-1:0]  r_rad, n_rad;

    // Unit hookup
    logic                     m0_start, m1_start, sq_start;
    logic signed [WA-1:0]     m0_a, m1_a;
    logic        [WB-1:0]     m0_b, m1_b;
    logic                     m0_busy, m1_busy, sq_busy;
    logic signed [WP-1:0]     w_p0, w_p1;
    logic        [ROOT_W-1:0] w_root;

    // Derived values
    logic [MAP_W-1:0]         w_mh_m1, w_mw_m1;
    logic [WPS-1:0]           w_ground, w_xmax;
    logic signed [WSUM-1:0]   w_gnd_s, w_xmax_s;
    logic [GRAV_W-1:0]        w_acc;
    logic signed [VEL_W:0]    w_vn_ext, w_mag_full;
    logic [VEL_W-1:0]         w_mag;
    logic signed [WP-1:0]     w_p0_sh, w_p0_sh1, w_p1_sh;
    logic [RAD_W-1:0]         w_sq, w_drop;
    logic signed [VEL_W-1:0]  w_root_s;
    logic                     w_hi, w_lo;
    logic                     w_in_acc, w_out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    assign w_in_acc   = s_axis_tvalid && (r_state == ST_IDLE);
    assign w_out_free = !r_ovalid || m_axis_tready;

    // Map limits in fixed point
    always_comb begin
        w_mh_m1  = (r_mh != '0) ? r_mh - 1'b1 : '0;
        w_mw_m1  = (r_mw != '0) ? r_mw - 1'b1 : '0;
        w_ground = WPS'({w_mh_m1, {F{1'b0}}});
        w_xmax   = WPS'({w_mw_m1, {F{1'b0}}});
        w_gnd_s  = signed'(WSUM'(w_ground));
        w_xmax_s = signed'(WSUM'(w_xmax));
    end

    // Gravity is off when resting on the ground
    assign w_acc = ((r_py == w_ground) && (r_vy == '0)) ? '0 : r_g;

    // |vy| as unsigned, 2^31 included
    always_comb begin
        w_vn_ext   = (VEL_W+1)'(r_vn);
        w_mag_full = (w_vn_ext < 0) ? -w_vn_ext : w_vn_ext;
        w_mag      = w_mag_full[VEL_W-1:0];
    end

    // Product scaling (arithmetic shift gives floor)
    always_comb begin
        w_p0_sh  = w_p0 >>> F;
        w_p0_sh1 = w_p0 >>> (F + 1);
        w_p1_sh  = w_p1 >>> F;
        w_sq     = w_p0[RAD_W-1:0];
        w_drop   = {w_p1[RAD_W-2:0], 1'b0};
        w_root_s = signed'(w_root);
        w_hi     = (r_sy > w_gnd_s);
        w_lo     = (r_sy < 0);
    end

    // Multiplier operand selection
    always_comb begin
        m0_start = 1'b0;
        m1_start = 1'b0;
        m0_a     = '0;
        m1_a     = '0;
        m0_b     = '0;
        m1_b     = '0;
        case (r_state)
            ST_M1: begin
                m0_start = 1'b1;
                m1_start = 1'b1;
                m0_a     = signed'(WA'(w_acc));
                m0_b     = WB'(r_dt);
                m1_a     = WA'(r_vx);
                m1_b     = WB'(r_dt);
            end
            ST_M2: begin
                m0_start = 1'b1;
                m0_a     = WA'(r_vy) + WA'(r_vn);
                m0_b     = WB'(r_dt);
            end
            ST_M3: begin
                m0_start = 1'b1;
                m1_start = 1'b1;
                m0_a     = signed'(WA'(w_mag));
                m0_b     = w_mag;
                m1_a     = signed'(WA'(r_ov));
                m1_b     = WB'(r_g);
            end
            ST_M4: begin
                m0_start = 1'b1;
                m1_start = 1'b1;
                m0_a     = -WA'(r_vx);
                m1_a     = -WA'(r_vn);
                m0_b     = WB'(r_rest);
                m1_b     = WB'(r_rest);
            end
            default: begin
            end
        endcase
    end

    assign sq_start = (r_state == ST_SQS);

    // Sequencer and datapath next values
    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_out    = r_out;
        n_px     = r_px;
        n_py     = r_py;
        n_vx     = r_vx;
        n_vy     = r_vy;
        n_vn     = r_vn;
        n_sx     = r_sx;
        n_sy     = r_sy;
        n_ov     = r_ov;
        n_rad    = r_rad;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser[0]) begin
                        n_px    = WPS'(s_axis_tdata[POS_W-1:0]);
                        n_py    = WPS'(s_axis_tdata[2*POS_W-1:POS_W]);
                        n_vx    = signed'(s_axis_tdata[2*POS_W+VEL_W-1:2*POS_W]);
                        n_vy    = signed'(s_axis_tdata[2*POS_W+2*VEL_W-1:2*POS_W+VEL_W]);
                        n_vn    = signed'(s_axis_tdata[2*POS_W+2*VEL_W-1:2*POS_W+VEL_W]);
                        n_state = ST_OUT;
                    end else begin
                        n_state = ST_M1;
                    end
                end
            end
            ST_M1: n_state = ST_W1;
            // New vy and unclamped x
            ST_W1: begin
                if (!m0_busy && !m1_busy) begin
                    n_vn    = f_sat(WP'(r_vy) + w_p0_sh);
                    n_sx    = WSUM'(signed'(WP'(r_px)) + w_p1_sh);
                    n_state = ST_M2;
                end
            end
            ST_M2: n_state = ST_W2;
            // Trapezoid step for y
            ST_W2: begin
                if (!m0_busy) begin
                    n_sy    = WSUM'(signed'(WP'(r_py)) + w_p0_sh1);
                    n_state = ST_CHK;
                end
            end
            // Crossing test, overshoot, clamp to map
            ST_CHK: begin
                n_ov = w_hi ? unsigned'(r_sy - w_gnd_s) : unsigned'(-r_sy);
                if (r_sx <= 0) begin
                    n_px = '0;
                end else if (r_sx >= w_xmax_s) begin
                    n_px = w_xmax;
                end else begin
                    n_px = r_sx[WPS-1:0];
                end
                if (r_sy <= 0) begin
                    n_py = '0;
                end else if (r_sy >= w_gnd_s) begin
                    n_py = w_ground;
                end else begin
                    n_py = r_sy[WPS-1:0];
                end
                n_state = (w_hi || w_lo) ? ST_M3 : ST_BCHK;
            end
            ST_M3: n_state = ST_W3;
            // Radicand v^2 - 2*g*overshoot, negative clamps to zero
            ST_W3: begin
                if (!m0_busy && !m1_busy) begin
                    n_rad   = (w_sq > w_drop) ? w_sq - w_drop : '0;
                    n_state = ST_SQS;
                end
            end
            ST_SQS: n_state = ST_SQW;
            // Rescaled speed keeps the sign of vy
            ST_SQW: begin
                if (!sq_busy) begin
                    if (r_vn < 0) begin
                        n_vn = -w_root_s;
                    end else if (r_vn > 0) begin
                        n_vn = w_root_s;
                    end else begin
                        n_vn = '0;
                    end
                    n_state = ST_BCHK;
                end
            end
            // Bounce when on the ground and still moving down
            ST_BCHK: begin
                n_state = ((r_py == w_ground) && (r_vn > 0)) ? ST_M4 : ST_OUT;
            end
            ST_M4: n_state = ST_W4;
            ST_W4: begin
                if (!m0_busy && !m1_busy) begin
                    n_vx    = f_sat(w_p0_sh);
                    n_vn    = f_sat(w_p1_sh);
                    n_state = ST_OUT;
                end
            end
            // Commit and hand the word to the output register
            ST_OUT: begin
                if (w_out_free) begin
                    n_vy     = r_vn;
                    n_out    = OUT_DATA_W'({(r_py == w_ground), r_vn, r_vx,
                                            r_py[POS_W-1:0], r_px[POS_W-1:0]});
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control and body state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_px     <= '0;
            r_py     <= '0;
            r_vx     <= '0;
            r_vy     <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_px     <= n_px;
            r_py     <= n_py;
            r_vx     <= n_vx;
            r_vy     <= n_vy;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        r_vn  <= n_vn;
        r_sx  <= n_sx;
        r_sy  <= n_sy;
        r_ov  <= n_ov;
        r_rad <= n_rad;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g    <= GRAVITY_RST;
            r_dt   <= TIME_STEP_RST;
            r_rest <= RESTITUTION_RST;
            r_mw   <= MAP_WIDTH_RST;
            r_mh   <= MAP_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GRAVITY:     r_g    <= i_cfg_data[GRAV_W-1:0];
                CFG_TIME_STEP:   r_dt   <= i_cfg_data[STEP_W-1:0];
                CFG_RESTITUTION: r_rest <= i_cfg_data[REST_W-1:0];
                CFG_MAP_WIDTH:   r_mw   <= i_cfg_data[MAP_W-1:0];
                CFG_MAP_HEIGHT:  r_mh   <= i_cfg_data[MAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    gbbs_mul_serial #(
        .WA (WA),
        .WB (WB)
    ) u_mul0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (m0_start),
        .i_a     (m0_a),
        .i_b     (m0_b),
        .o_busy  (m0_busy),
        .o_prod  (w_p0)
    );

    gbbs_mul_serial #(
        .WA (WA),
        .WB (WB)
    ) u_mul1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (m1_start),
        .i_a     (m1_a),
        .i_b     (m1_b),
        .o_busy  (m1_busy),
        .o_prod  (w_p1)
    );

    gbbs_sqrt_serial u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_rad),
        .o_busy  (sq_busy),
        .o_root  (w_root)
    );

endmodule

`default_nettype wire
